// File: rtl/core/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur stream.
package bb3_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MIN_SIZE       = 3;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = CH_W * NUM_CH;
	localparam int WIN_CELLS  = 9;
	localparam int WIN_COLS   = 6;
	localparam int NUM_RES    = 4;
	localparam int RES_IDX_W  = 2;
	localparam int OUT_POS_W  = 10;

	localparam int IN_TDATA_W  = PIX_W;
	localparam int OUT_USED_W  = PIX_W + 2 * OUT_POS_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(640);
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(480);
	localparam logic                  MODE_RESET   = 1'b1;

	// floor(s / 9) == (s * 3641) >> 15 for every s below 32768
	localparam int SUM_W      = 12;
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t                px;
		logic [OUT_POS_W-1:0]  row;
		logic [OUT_POS_W-1:0]  col;
	} result_t;

endpackage

// File: rtl/core/box_blur_3x3_stream.sv
// Top level of the 3x3 box blur on a raster-order pixel stream.
// A pixel's results are formed in the input stage and registered into the m_axis stage.
// Throughput: one pixel per cycle while m_axis accepts; a pixel with n results holds
// the output for n transfers and stalls input: row ends, last-row pixels (2), frame corner (4).
// Reset: position (0,0), window zero, 640x480 colour; line store not cleared.
module box_blur_3x3_stream #(
	parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// blue_or_gray, green_in, red_in
	input  logic [bb3_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_blue_or_gray, out_green, out_red, out_row, out_col, zero pad
	output logic [bb3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bb3_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int XW  = (AW > OUT_POS_W) ? AW : OUT_POS_W;
	localparam int YW  = ($clog2(MAX_HEIGHT) > OUT_POS_W) ? $clog2(MAX_HEIGHT) : OUT_POS_W;
	localparam int SXW = (XW + 1 > CFG_DATA_W) ? XW + 1 : CFG_DATA_W;
	localparam int SYW = (YW + 1 > CFG_DATA_W) ? YW + 1 : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic                  colour_q;

	logic [SXW-1:0] w_ext, w_clamp;
	logic [SYW-1:0] h_ext, h_clamp;
	logic [XW-1:0]  w_last;
	logic [YW-1:0]  h_last;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	logic          in_acc;
	logic          s1_v;
	logic          s1_adv;
	pixel_t        cur_s1;
	logic [XW-1:0] col_s1;
	logic [YW-1:0] row_s1;

	logic [2*PIX_W-1:0] lines_rd;
	pixel_t             up2, up1;
	pixel_t             win_q [WIN_COLS];
	pixel_t [WIN_CELLS-1:0] cells;
	pixel_t             blur;

	result_t [NUM_RES-1:0] res;
	logic [NUM_RES-1:0]    res_mask;
	logic                  interior;

	result_t [NUM_RES-1:0] res_s2;
	logic [NUM_RES-1:0]    mask_s2;
	logic [RES_IDX_W-1:0]  sel;
	logic [NUM_RES-1:0]    remain;
	logic                  s2_free;
	logic                  out_acc;
	result_t               out_res;

	always_comb begin
		w_ext = SXW'(width_q);
		if (w_ext < SXW'(MIN_SIZE)) begin
			w_clamp = SXW'(MIN_SIZE);
		end else if (w_ext > SXW'(MAX_WIDTH)) begin
			w_clamp = SXW'(MAX_WIDTH);
		end else begin
			w_clamp = w_ext;
		end
		w_last = XW'(w_clamp - SXW'(1));

		h_ext = SYW'(height_q);
		if (h_ext < SYW'(MIN_SIZE)) begin
			h_clamp = SYW'(MIN_SIZE);
		end else if (h_ext > SYW'(MAX_HEIGHT)) begin
			h_clamp = SYW'(MAX_HEIGHT);
		end else begin
			h_clamp = h_ext;
		end
		h_last = YW'(h_clamp - SYW'(1));
	end

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !s1_v || s1_adv;
	assign s1_adv        = s1_v && s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			colour_q <= MODE_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (in_acc) begin
				if (col_q == w_last) begin
					col_q <= '0;
					row_q <= (row_q == h_last) ? '0 : row_q + YW'(1);
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WIDTH: begin
						width_q <= cfg_data;
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_HEIGHT: begin
						height_q <= cfg_data;
						col_q    <= '0;
						row_q    <= '0;
					end
					REG_MODE: begin
						colour_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s_axis_tready) begin
			s1_v <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1 <= s_axis_tdata[PIX_W-1:0];
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// newer row in the upper half, older row in the lower half
	bb3_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PIX_W),
		.AW    (AW)
	) u_lines (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1[AW-1:0]),
		.wr_data ({cur_s1, up1}),
		.rd_en   (in_acc),
		.rd_addr (col_q[AW-1:0]),
		.rd_data (lines_rd)
	);

	assign up2 = lines_rd[PIX_W-1:0];
	assign up1 = lines_rd[2*PIX_W-1:PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_COLS; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= up2;
			win_q[1] <= up1;
			win_q[2] <= cur_s1;
		end
	end

	always_comb begin
		cells[0] = up2;
		cells[1] = up1;
		cells[2] = cur_s1;
		for (int i = 0; i < WIN_COLS; i++) begin
			cells[3 + i] = win_q[i];
		end
	end

	bb3_mean u_mean (
		.cells (cells),
		.mean  (blur)
	);

	always_comb begin
		interior = (row_s1 >= YW'(2)) && (col_s1 >= XW'(2));

		res[0].px  = interior ? blur : win_q[1];
		res[0].row = OUT_POS_W'(row_s1 - YW'(1));
		res[0].col = OUT_POS_W'(col_s1 - XW'(1));
		res_mask[0] = (row_s1 != '0) && (col_s1 != '0);

		res[1].px  = up1;
		res[1].row = OUT_POS_W'(row_s1 - YW'(1));
		res[1].col = OUT_POS_W'(col_s1);
		res_mask[1] = (row_s1 != '0) && (col_s1 == w_last);

		res[2].px  = win_q[2];
		res[2].row = OUT_POS_W'(row_s1);
		res[2].col = OUT_POS_W'(col_s1 - XW'(1));
		res_mask[2] = (row_s1 == h_last) && (col_s1 != '0);

		res[3].px  = cur_s1;
		res[3].row = OUT_POS_W'(row_s1);
		res[3].col = OUT_POS_W'(col_s1);
		res_mask[3] = (row_s1 == h_last) && (col_s1 == w_last);
	end

	always_comb begin
		sel = '0;
		for (int i = NUM_RES - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				sel = RES_IDX_W'(i);
			end
		end
		remain = mask_s2 & ~(NUM_RES'(1) << sel);
	end

	assign m_axis_tvalid = mask_s2 != '0;
	assign m_axis_tlast  = remain == '0;
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign s2_free       = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);
	assign out_res       = res_s2[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (s1_adv) begin
			mask_s2 <= res_mask;
		end else if (out_acc) begin
			mask_s2 <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tdata = {
		{OUT_PAD_W{1'b0}},
		out_res.col,
		out_res.row,
		colour_q ? out_res.px[2*CH_W +: CH_W] : {CH_W{1'b0}},
		colour_q ? out_res.px[CH_W +: CH_W] : {CH_W{1'b0}},
		out_res.px[0 +: CH_W]
	};

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last)
		else $error("column counter beyond row width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last)
		else $error("row counter beyond frame height");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_v)
		else $error("accepted pixel lost before input stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !s1_adv) |=> (s1_v && $stable(col_s1) && $stable(row_s1)))
		else $error("stalled input stage changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast && !s1_adv) |=> !m_axis_tvalid)
		else $error("result bundle not emptied after last transaction");

endmodule

// File: rtl/core/bb3_line_store.sv
// Dual line store: one memory holding the two previous rows per column.
module bb3_line_store #(
	parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF,
	parameter int DW    = 2 * bb3_pkg::PIX_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/bb3_mean.sv
// Per-channel floor mean of a 3x3 pixel neighbourhood.
module bb3_mean (
	input  bb3_pkg::pixel_t [bb3_pkg::WIN_CELLS-1:0] cells,
	output bb3_pkg::pixel_t                          mean
);
	import bb3_pkg::*;

	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [2*SUM_W-1:0] p;
		p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
		return p[DIV9_SHIFT +: CH_W];
	endfunction

	logic [SUM_W-1:0] sum [NUM_CH];

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			sum[k] = '0;
			for (int i = 0; i < WIN_CELLS; i++) begin
				sum[k] = sum[k] + SUM_W'(cells[i][k*CH_W +: CH_W]);
			end
			mean[k*CH_W +: CH_W] = div9(sum[k]);
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 box blur stream, with a scoreboard that mirrors the filter.
module testbench;
	import bb3_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int MAX_H         = MAX_HEIGHT_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 28;
	localparam int FINAL_ITEMS   = 12;
	localparam int BLUE_LO       = 0;
	localparam int GREEN_LO      = CH_W;
	localparam int RED_LO        = 2 * CH_W;
	localparam int ROW_LO        = PIX_W;
	localparam int COL_LO        = PIX_W + OUT_POS_W;

	typedef struct {
		logic [CH_W-1:0]      blue;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      red;
		logic [OUT_POS_W-1:0] row;
		logic [OUT_POS_W-1:0] col;
		logic                 last;
	} blur_out_t;

	class blur_scoreboard;
		pixel_t                older_row[MAX_W] = '{default: '0};
		pixel_t                newer_row[MAX_W] = '{default: '0};
		pixel_t                window[WIN_COLS] = '{default: '0};
		int unsigned           row_pos = 0;
		int unsigned           col_pos = 0;
		logic [CFG_DATA_W-1:0] width_reg = WIDTH_RESET;
		logic [CFG_DATA_W-1:0] height_reg = HEIGHT_RESET;
		logic                  colour = MODE_RESET;
		blur_out_t             expected_q[$];
		int                    failures = 0;

		function int unsigned clamp(logic [CFG_DATA_W-1:0] v, int unsigned hi);
			if (v < MIN_SIZE)
				return MIN_SIZE;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int unsigned frame_pixels();
			return clamp(width_reg, MAX_W) * clamp(height_reg, MAX_H);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WIDTH: begin
					width_reg = val;
					row_pos = 0;
					col_pos = 0;
				end
				REG_HEIGHT: begin
					height_reg = val;
					row_pos = 0;
					col_pos = 0;
				end
				REG_MODE: begin
					colour = val[0];
				end
				default: ;
			endcase
		endfunction

		function void push_result(int unsigned r, int unsigned c, pixel_t px);
			blur_out_t o;
			o.blue  = px[BLUE_LO +: CH_W];
			o.green = colour ? px[GREEN_LO +: CH_W] : '0;
			o.red   = colour ? px[RED_LO +: CH_W] : '0;
			o.row   = r[OUT_POS_W-1:0];
			o.col   = c[OUT_POS_W-1:0];
			o.last  = 1'b0;
			expected_q.push_back(o);
		endfunction

		function void note_pixel(pixel_t cur);
			int unsigned      w, h, r, c, queued;
			pixel_t           up2, up1, px;
			logic [SUM_W-1:0] sum;
			w = clamp(width_reg, MAX_W);
			h = clamp(height_reg, MAX_H);
			r = (row_pos >= h) ? h - 1 : row_pos;
			c = (col_pos >= w) ? w - 1 : col_pos;
			queued = expected_q.size();
			up2 = older_row[c];
			up1 = newer_row[c];
			older_row[c] = up1;
			newer_row[c] = cur;
			if (r >= 1 && c >= 1) begin
				px = window[1];
				if (r - 1 >= 1 && r - 1 <= h - 2 && c - 1 >= 1 && c - 1 <= w - 2) begin
					px = '0;
					for (int k = 0; k < NUM_CH; k++) begin
						sum = up2[k*CH_W +: CH_W] + up1[k*CH_W +: CH_W] + cur[k*CH_W +: CH_W];
						for (int i = 0; i < WIN_COLS; i++)
							sum += window[i][k*CH_W +: CH_W];
						px[k*CH_W +: CH_W] = sum / WIN_CELLS;
					end
				end
				push_result(r - 1, c - 1, px);
			end
			if (r >= 1 && c == w - 1)
				push_result(r - 1, c, up1);
			if (r == h - 1) begin
				if (c >= 1)
					push_result(r, c - 1, window[2]);
				if (c == w - 1)
					push_result(r, c, cur);
			end
			if (expected_q.size() > queued)
				expected_q[$].last = 1'b1;
			window[3] = window[0];
			window[4] = window[1];
			window[5] = window[2];
			window[0] = up2;
			window[1] = up1;
			window[2] = cur;
			if (c == w - 1) begin
				col_pos = 0;
				row_pos = (r == h - 1) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end
		endfunction

		function void compare(string field, logic [OUT_POS_W-1:0] want,
				logic [OUT_POS_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_output(logic [OUT_TDATA_W-1:0] data, logic last);
			blur_out_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result at row %0d col %0d",
					data[ROW_LO +: OUT_POS_W], data[COL_LO +: OUT_POS_W]);
				failures++;
				return;
			end
			e = expected_q.pop_front();
			compare("out_blue_or_gray", e.blue, data[BLUE_LO +: CH_W]);
			compare("out_green", e.green, data[GREEN_LO +: CH_W]);
			compare("out_red", e.red, data[RED_LO +: CH_W]);
			compare("out_row", e.row, data[ROW_LO +: OUT_POS_W]);
			compare("out_col", e.col, data[COL_LO +: OUT_POS_W]);
			compare("last_of_run", e.last, last);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	pixel_t                 s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int unsigned            send_idle_pct = 0;
	int unsigned            recv_idle_pct = 0;
	blur_scoreboard         board = new;

	box_blur_3x3_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial forever #4 clk = ~clk;

	initial begin
		#8000000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_output(m_axis_tdata, m_axis_tlast);
	end

	function automatic pixel_t rand_pixel();
		pixel_t px;
		for (int k = 0; k < NUM_CH; k++) begin
			case ($urandom_range(7))
				0: px[k*CH_W +: CH_W] = '0;
				1: px[k*CH_W +: CH_W] = '1;
				default: px[k*CH_W +: CH_W] = CH_W'($urandom_range(255));
			endcase
		end
		return px;
	endfunction

	task automatic send_pixel(pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_pixel(px);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(rand_pixel());
	endtask

	initial begin
		int unsigned pick, count, random_sent;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_random(5);
		settle();
		write_reg(REG_SPARE, '1);
		write_reg(REG_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_HEIGHT, CFG_DATA_W'(3));
		write_reg(REG_MODE, CFG_DATA_W'(1));
		for (int i = 0; i < 9; i++)
			send_pixel('1);
		settle();
		write_reg(REG_WIDTH, '0);
		write_reg(REG_HEIGHT, CFG_DATA_W'(1));
		write_reg(REG_MODE, CFG_DATA_W'(0));
		for (int i = 0; i < 9; i++)
			send_pixel(i[0] ? 24'h00FF00 : 24'hFF00FF);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_sent = 0;
			while (random_sent < RANDOM_ITEMS) begin
				settle();
				pick = $urandom_range(9);
				if (pick != 0) begin
					write_reg(REG_WIDTH, (pick == 1) ? CFG_DATA_W'($urandom_range(2))
						: CFG_DATA_W'($urandom_range(3, 7)));
					write_reg(REG_HEIGHT, (pick == 2) ? CFG_DATA_W'($urandom_range(2))
						: CFG_DATA_W'($urandom_range(3, 6)));
				end
				write_reg(REG_MODE, CFG_DATA_W'($urandom_range(1)));
				if (pick == 3)
					write_reg(REG_SPARE, CFG_DATA_W'($urandom));
				count = ($urandom_range(3) == 0) ? $urandom_range(1, board.frame_pixels())
					: board.frame_pixels();
				if (count > RANDOM_ITEMS - random_sent)
					count = RANDOM_ITEMS - random_sent;
				send_random(count);
				random_sent += count;
			end
		end

		settle();
		write_reg(REG_WIDTH, CFG_DATA_W'(1024));
		write_reg(REG_HEIGHT, CFG_DATA_W'(3));
		write_reg(REG_MODE, CFG_DATA_W'($urandom_range(1)));
		send_random(FINAL_ITEMS);
		settle();
		write_reg(REG_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_HEIGHT, '1);
		write_reg(REG_MODE, CFG_DATA_W'($urandom_range(1)));
		send_random(FINAL_ITEMS);
		settle();

		if (board.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
